/* rtl/core/pwtc_pkg.sv */
// Shared constants for the PID controller with per-term clamps.
`default_nettype none

package pwtc_pkg;

   // Gains are signed fixed point with a fixed total width.
   localparam int GAIN_WIDTH = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROP_LIMITS  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEG_LIMITS = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DERIV_LIMITS = 3'd5;

endpackage

`default_nettype wire

/* rtl/core/pid_with_term_clamps_unit.sv */
// Top level of the fixed-point PID controller with a clamp on each term.
`default_nettype none

// Channel   Direction  Beat contents
// req_      in         tdata: measured, setpoint (signed samples)
// rsp_      out        tdata: drive (signed sum of the clamped terms)
// csr_      in         index and data of one configuration register write
//
// Each sample beat is captured in an input register; from there the error, the
// three gain products, the integral update and the clamps are computed, and the
// drive value is written into the result register once that register is free.
// One beat per cycle is sustained while the response side is not stalled.
// The integral and derivative history lives in the term registers, updated
// as each beat moves into the result register. Reset is synchronous and
// clears the history, the configuration and both valid flags. A stalled
// response holds the result register; the input register keeps taking beats
// whenever its content moves on in the same cycle.

module pid_with_term_clamps_unit #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8,
   parameter int TERM_WIDTH     = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // measured [SAMPLE_WIDTH-1:0], setpoint [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH], zero fill
   input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // drive [TERM_WIDTH+1:0], zero fill
   output logic [((TERM_WIDTH+2+7)/8)*8-1:0]           rsp_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [pwtc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [2*TERM_WIDTH-1:0]                csr_data
);

   localparam int GW      = pwtc_pkg::GAIN_WIDTH;
   localparam int RSP_W   = ((TERM_WIDTH+2+7)/8)*8;
   localparam int ERR_W   = SAMPLE_WIDTH + 1;
   localparam int DIFF_W  = SAMPLE_WIDTH + 2;
   localparam int PROD_W  = ERR_W + GW;
   localparam int DPROD_W = DIFF_W + GW;
   localparam int P_W     = (PROD_W > TERM_WIDTH) ? PROD_W : TERM_WIDTH;
   localparam int I_W     = P_W + 1;
   localparam int D_W     = (DPROD_W > TERM_WIDTH) ? DPROD_W : TERM_WIDTH;
   localparam int DRIVE_W = TERM_WIDTH + 2;

   // Configuration
   logic signed [GW-1:0]           prop_gain;
   logic signed [GW-1:0]           integ_gain;
   logic signed [GW-1:0]           deriv_gain;
   logic [2*TERM_WIDTH-1:0]        prop_limits;
   logic [2*TERM_WIDTH-1:0]        integ_limits;
   logic [2*TERM_WIDTH-1:0]        deriv_limits;

   // Input register
   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] measured_ff;
   logic signed [SAMPLE_WIDTH-1:0] setpoint_ff;

   // Controller history
   logic                           first_pass_ff;
   logic signed [TERM_WIDTH-1:0]   prop_term_ff;
   logic signed [TERM_WIDTH-1:0]   integ_term_ff;
   logic signed [TERM_WIDTH-1:0]   deriv_term_ff;
   logic signed [ERR_W-1:0]        prev_error_ff;

   // Result register
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [DRIVE_W-1:0]      drive_ff;

   // Datapath
   logic                           out_free;
   logic                           advance;
   logic                           req_take;
   logic signed [ERR_W-1:0]        error;
   logic signed [DIFF_W-1:0]       error_diff;
   logic signed [PROD_W-1:0]       prod_p;
   logic signed [PROD_W-1:0]       prod_i;
   logic signed [DPROD_W-1:0]      prod_d;
   logic signed [P_W-1:0]          raw_p;
   logic signed [I_W-1:0]          raw_i;
   logic signed [D_W-1:0]          raw_d;
   logic signed [TERM_WIDTH-1:0]   clamp_p;
   logic signed [TERM_WIDTH-1:0]   clamp_i;
   logic signed [TERM_WIDTH-1:0]   clamp_d;
   logic signed [DRIVE_W-1:0]      drive_sum;

   pwtc_csr #(
      .TERM_WIDTH (TERM_WIDTH)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .prop_gain    (prop_gain),
      .integ_gain   (integ_gain),
      .deriv_gain   (deriv_gain),
      .prop_limits  (prop_limits),
      .integ_limits (integ_limits),
      .deriv_limits (deriv_limits)
   );

   // Flow control: the result register frees up when it is empty or taken,
   // and the input register moves a held sample into it only when it is free.
   assign out_free     = ~rsp_valid_ff | rsp_tready;
   assign advance      = in_valid_ff & out_free;
   assign req_tready   = ~in_valid_ff | out_free;
   assign req_take     = req_tvalid & req_tready;
   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         measured_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         setpoint_ff <= req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      end
   end

   // Error and the three gain products. The arithmetic shift right is a
   // floor division by the gain scale.
   assign error      = ERR_W'(setpoint_ff) - ERR_W'(measured_ff);
   assign error_diff = DIFF_W'(error) - DIFF_W'(prev_error_ff);
   assign prod_p     = PROD_W'(error) * PROD_W'(prop_gain);
   assign prod_i     = PROD_W'(error) * PROD_W'(integ_gain);
   assign prod_d     = DPROD_W'(error_diff) * DPROD_W'(deriv_gain);

   // On the first sample after reset the stored terms are only re-clamped.
   always_comb begin
      if (first_pass_ff) begin
         raw_p = P_W'(prop_term_ff);
         raw_i = I_W'(integ_term_ff);
         raw_d = D_W'(deriv_term_ff);
      end else begin
         raw_p = P_W'(prod_p >>> GAIN_FRAC_BITS);
         raw_i = I_W'(integ_term_ff) + I_W'(prod_i >>> GAIN_FRAC_BITS);
         raw_d = D_W'(prod_d >>> GAIN_FRAC_BITS);
      end
   end

   pwtc_clamp #(
      .IN_WIDTH   (P_W),
      .TERM_WIDTH (TERM_WIDTH)
   ) u_clamp_p (
      .raw_value (raw_p),
      .limits    (prop_limits),
      .clamped   (clamp_p)
   );

   pwtc_clamp #(
      .IN_WIDTH   (I_W),
      .TERM_WIDTH (TERM_WIDTH)
   ) u_clamp_i (
      .raw_value (raw_i),
      .limits    (integ_limits),
      .clamped   (clamp_i)
   );

   pwtc_clamp #(
      .IN_WIDTH   (D_W),
      .TERM_WIDTH (TERM_WIDTH)
   ) u_clamp_d (
      .raw_value (raw_d),
      .limits    (deriv_limits),
      .clamped   (clamp_d)
   );

   assign drive_sum = DRIVE_W'(clamp_p) + DRIVE_W'(clamp_i) + DRIVE_W'(clamp_d);

   // The history advances together with the sample that uses it.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_pass_ff <= 1'b1;
         prop_term_ff  <= '0;
         integ_term_ff <= '0;
         deriv_term_ff <= '0;
         prev_error_ff <= '0;
      end else if (advance) begin
         first_pass_ff <= 1'b0;
         prop_term_ff  <= clamp_p;
         integ_term_ff <= clamp_i;
         deriv_term_ff <= clamp_d;
         prev_error_ff <= error;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff <= drive_sum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(unsigned'(drive_ff));

endmodule

`default_nettype wire

/* rtl/core/pwtc_csr.sv */
// Configuration register file: gains and clamp limits of the three terms.
`default_nettype none

module pwtc_csr #(
   parameter int TERM_WIDTH = 24
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [pwtc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [2*TERM_WIDTH-1:0]                 csr_data,
   output logic signed [pwtc_pkg::GAIN_WIDTH-1:0]       prop_gain,
   output logic signed [pwtc_pkg::GAIN_WIDTH-1:0]       integ_gain,
   output logic signed [pwtc_pkg::GAIN_WIDTH-1:0]       deriv_gain,
   output logic [2*TERM_WIDTH-1:0]                      prop_limits,
   output logic [2*TERM_WIDTH-1:0]                      integ_limits,
   output logic [2*TERM_WIDTH-1:0]                      deriv_limits
);

   logic signed [pwtc_pkg::GAIN_WIDTH-1:0] prop_gain_ff;
   logic signed [pwtc_pkg::GAIN_WIDTH-1:0] integ_gain_ff;
   logic signed [pwtc_pkg::GAIN_WIDTH-1:0] deriv_gain_ff;
   logic [2*TERM_WIDTH-1:0]                prop_limits_ff;
   logic [2*TERM_WIDTH-1:0]                integ_limits_ff;
   logic [2*TERM_WIDTH-1:0]                deriv_limits_ff;
   logic                                   write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= '0;
         integ_gain_ff   <= '0;
         deriv_gain_ff   <= '0;
         prop_limits_ff  <= '0;
         integ_limits_ff <= '0;
         deriv_limits_ff <= '0;
      end else if (write_en) begin
         unique case (csr_index)
            pwtc_pkg::CSR_PROP_GAIN:
               prop_gain_ff <= csr_data[pwtc_pkg::GAIN_WIDTH-1:0];
            pwtc_pkg::CSR_INTEG_GAIN:
               integ_gain_ff <= csr_data[pwtc_pkg::GAIN_WIDTH-1:0];
            pwtc_pkg::CSR_DERIV_GAIN:
               deriv_gain_ff <= csr_data[pwtc_pkg::GAIN_WIDTH-1:0];
            pwtc_pkg::CSR_PROP_LIMITS:  prop_limits_ff  <= csr_data;
            pwtc_pkg::CSR_INTEG_LIMITS: integ_limits_ff <= csr_data;
            pwtc_pkg::CSR_DERIV_LIMITS: deriv_limits_ff <= csr_data;
            default: begin
               // Unused indexes are ignored.
            end
         endcase
      end
   end

   assign prop_gain    = prop_gain_ff;
   assign integ_gain   = integ_gain_ff;
   assign deriv_gain   = deriv_gain_ff;
   assign prop_limits  = prop_limits_ff;
   assign integ_limits = integ_limits_ff;
   assign deriv_limits = deriv_limits_ff;

endmodule

`default_nettype wire

/* rtl/core/pwtc_clamp.sv */
// Clamp of one term: raise to the minimum first, then lower to the maximum.
`default_nettype none

module pwtc_clamp #(
   parameter int IN_WIDTH   = 34,
   parameter int TERM_WIDTH = 24
) (
   input  wire logic signed [IN_WIDTH-1:0]   raw_value,
   input  wire logic [2*TERM_WIDTH-1:0]      limits,
   output logic signed [TERM_WIDTH-1:0]      clamped
);

   logic signed [IN_WIDTH-1:0] lo_ext;
   logic signed [IN_WIDTH-1:0] hi_ext;
   logic signed [IN_WIDTH-1:0] raised;
   logic signed [IN_WIDTH-1:0] lowered;

   assign lo_ext  = IN_WIDTH'(signed'(limits[TERM_WIDTH-1:0]));
   assign hi_ext  = IN_WIDTH'(signed'(limits[2*TERM_WIDTH-1:TERM_WIDTH]));
   assign raised  = (raw_value < lo_ext) ? lo_ext : raw_value;
   // When the minimum lies above the maximum the maximum wins.
   assign lowered = (raised > hi_ext) ? hi_ext : raised;
   assign clamped = lowered[TERM_WIDTH-1:0];

endmodule

`default_nettype wire

/* rtl/core/pwtc_checker.sv */
// Port-level checks of the PID controller, bound to its top level.
`default_nettype none

module pwtc_checker #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int TERM_WIDTH   = 24
) (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,
   input wire logic                                   req_tvalid,
   input wire logic                                   req_tready,
   input wire logic [((TERM_WIDTH+2+7)/8)*8-1:0]      rsp_tdata,
   input wire logic                                   rsp_tvalid,
   input wire logic                                   rsp_tready,
   input wire logic                                   csr_valid,
   input wire logic                                   csr_ready
);

   localparam int RSP_W   = ((TERM_WIDTH+2+7)/8)*8;
   localparam int DRIVE_W = TERM_WIDTH + 2;

   logic rsp_fill_zero;
   logic unused_ok;

   assign rsp_fill_zero = (RSP_W == DRIVE_W) ? 1'b1 :
                          ((rsp_tdata >> DRIVE_W) == '0);
   assign unused_ok = (req_tvalid | ~req_tvalid) & (csr_valid | ~csr_valid)
                    & ((|req_tdata) | ~(|req_tdata));

   // A response held back keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // With the response side empty the input side never stalls.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // The byte fill above the drive value stays zero.
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_fill_zero && unused_ok)
      else $error("response padding not zero");

   // The configuration port takes every write at once.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write held off");

endmodule

bind pid_with_term_clamps_unit pwtc_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH),
   .TERM_WIDTH   (TERM_WIDTH)
) u_pwtc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);

`default_nettype wire

/* dv/pid_with_term_clamps_unit_tb.sv */
// Self-checking testbench for the PID controller with per-term clamps.
`timescale 1ns / 100ps

module pid_with_term_clamps_unit_tb;

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_FRAC   = 8;
   localparam int TERM_W      = 24;
   localparam int DRIVE_W     = TERM_W + 2;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   // The block holds at most two beats in flight, so once the settle wait after
   // the last response is over it is certainly idle.
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_SAMPLES = 250;

   // Register indexes past the end of the map; writes there must be ignored.
   localparam logic [pwtc_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [pwtc_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;

   // Limit words are {max, min}, each a signed term-width value.
   localparam logic [2*TERM_W-1:0] FULL_LIMITS = {24'h7FFFFF, 24'h800000};

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic [31:0]                          req_tdata = '0;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [31:0]                          rsp_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [pwtc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [2*TERM_W-1:0]                  csr_data = '0;

   pid_with_term_clamps_unit #(
      .SAMPLE_WIDTH   (SAMPLE_W),
      .GAIN_FRAC_BITS (GAIN_FRAC),
      .TERM_WIDTH     (TERM_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Sample beats waiting to be offered, packed as {setpoint, measured}.
   logic [31:0]        pending_samples[$];
   // Drive values the controller must produce, oldest first.
   logic [DRIVE_W-1:0] drive_expect[$];
   logic [DRIVE_W-1:0] drive_want;

   // Shadow copy of the configuration registers.
   logic signed [15:0]  gain_p = '0, gain_i = '0, gain_d = '0;
   logic [2*TERM_W-1:0] lim_p = '0, lim_i = '0, lim_d = '0;

   // Shadow copy of the controller history. The terms are kept wide here so
   // that the unclamped values never wrap before the clamp sees them.
   bit     awaiting_first = 1'b1;
   longint p_term = 0, i_term = 0, d_term = 0, last_error = 0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_start = 1'b0;
   int hold_left = 0;

   int error_count = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // The run must end on its own well before this; hitting it means the
   // block stopped producing results or stopped taking beats.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                  drive_expect.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Raise to the minimum first, then lower to the maximum, so a minimum
   // above the maximum leaves the term at the maximum.
   function automatic longint clamp_to(input longint v, input logic [2*TERM_W-1:0] lim);
      longint lo, hi;
      lo = longint'($signed(lim[TERM_W-1:0]));
      hi = longint'($signed(lim[2*TERM_W-1:TERM_W]));
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   // One controller step for an accepted sample beat. The first beat after
   // reset only clamps the stored terms; every later beat recomputes them.
   // The shift of a signed longint rounds toward minus infinity, as the
   // block does.
   task automatic advance_controller(input logic [31:0] beat);
      longint meas, setp, err, total;
      meas = longint'($signed(beat[SAMPLE_W-1:0]));
      setp = longint'($signed(beat[2*SAMPLE_W-1:SAMPLE_W]));
      err  = setp - meas;
      if (awaiting_first) begin
         awaiting_first = 1'b0;
      end else begin
         p_term = (err * longint'(gain_p)) >>> GAIN_FRAC;
         i_term = i_term + ((err * longint'(gain_i)) >>> GAIN_FRAC);
         d_term = ((err - last_error) * longint'(gain_d)) >>> GAIN_FRAC;
      end
      p_term = clamp_to(p_term, lim_p);
      i_term = clamp_to(i_term, lim_i);
      d_term = clamp_to(d_term, lim_d);
      total = p_term + i_term + d_term;
      last_error = err;
      drive_expect.push_back(total[DRIVE_W-1:0]);
   endtask

   // Sample driver. A beat stays on the bus until it is taken; the next one
   // is put up in the same edge when the sender is not idling.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_controller(req_tdata);
            samples_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tdata  <= pending_samples.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here and only read by the monitor.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // Result monitor: every response beat is checked against the oldest
   // expected drive value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected drive %0d",
                                      $signed(rsp_tdata[DRIVE_W-1:0])));
         end else begin
            drive_want = drive_expect.pop_front();
            if (rsp_tdata[DRIVE_W-1:0] !== drive_want) begin
               report_mismatch($sformatf("drive got %0d expected %0d",
                                         $signed(rsp_tdata[DRIVE_W-1:0]),
                                         $signed(drive_want)));
            end
            results_checked++;
         end
      end
      rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic queue_sample(input logic [15:0] meas, input logic [15:0] setp);
      pending_samples.push_back({setp, meas});
   endtask

   // Waits until every queued sample has been taken and answered, then lets
   // the pipeline settle so a register write lands on an idle block.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || drive_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the shadow copy follows at the accepting edge.
   task automatic write_csr(input logic [pwtc_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [2*TERM_W-1:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         pwtc_pkg::CSR_PROP_GAIN:    gain_p = value[15:0];
         pwtc_pkg::CSR_INTEG_GAIN:   gain_i = value[15:0];
         pwtc_pkg::CSR_DERIV_GAIN:   gain_d = value[15:0];
         pwtc_pkg::CSR_PROP_LIMITS:  lim_p  = value;
         pwtc_pkg::CSR_INTEG_LIMITS: lim_i  = value;
         pwtc_pkg::CSR_DERIV_LIMITS: lim_d  = value;
         default: ;
      endcase
   endtask

   // Gain flavors: any value, a full-scale extreme, or a small gain that
   // keeps the integral away from its clamps for a while.
   function automatic logic [15:0] make_gain(input int flavor);
      case (flavor)
         0:       return 16'($urandom);
         1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'(int'($urandom_range(0, 1200)) - 600);
      endcase
   endfunction

   // Limit flavors: full term range, any bit pattern (often a minimum above
   // the maximum), or a narrow window around zero.
   function automatic logic [2*TERM_W-1:0] make_limits(input int flavor);
      case (flavor)
         0:       return FULL_LIMITS;
         1:       return {16'($urandom), 32'($urandom)};
         default: return {24'($urandom_range(0, 5000)),
                          24'(-int'($urandom_range(0, 5000)))};
      endcase
   endfunction

   initial begin
      logic [15:0] track_base;
      int          delta;
      int          gain_flavor, lim_flavor;

      do @(negedge clock);
      while (reset);

      // Nothing configured yet: the first sample only clamps the cleared
      // terms, and with all limits at zero every drive value is zero.
      queue_sample(16'h8000, 16'h7FFF);
      queue_sample(16'h1234, 16'hFEDC);
      wait_drained();

      // Full-scale gains and full-range limits against the sample extremes,
      // so the error and its difference reach their widest values.
      write_csr(pwtc_pkg::CSR_PROP_GAIN,    {32'($urandom), 16'h7FFF});
      write_csr(pwtc_pkg::CSR_INTEG_GAIN,   {32'($urandom), 16'h8000});
      write_csr(pwtc_pkg::CSR_DERIV_GAIN,   {32'($urandom), 16'h7FFF});
      write_csr(pwtc_pkg::CSR_PROP_LIMITS,  FULL_LIMITS);
      write_csr(pwtc_pkg::CSR_INTEG_LIMITS, FULL_LIMITS);
      write_csr(pwtc_pkg::CSR_DERIV_LIMITS, FULL_LIMITS);
      queue_sample(16'h8000, 16'h7FFF);
      queue_sample(16'h7FFF, 16'h8000);
      queue_sample(16'h0000, 16'h0000);
      queue_sample(16'h7FFF, 16'h7FFF);
      queue_sample(16'h8000, 16'h8000);
      queue_sample(16'h0001, 16'h0000);
      queue_sample(16'h0000, 16'h0001);
      queue_sample(16'hFFFF, 16'h0000);
      wait_drained();

      // Floor rounding of small negative products, a proportional window
      // whose minimum lies above its maximum, a tight integral window and a
      // derivative window pinned at the top. The spare indexes must not
      // disturb any of it.
      write_csr(pwtc_pkg::CSR_PROP_GAIN,    {32'($urandom), 16'hFFFF});
      write_csr(pwtc_pkg::CSR_INTEG_GAIN,   {32'($urandom), 16'h0001});
      write_csr(pwtc_pkg::CSR_DERIV_GAIN,   {32'($urandom), 16'h8000});
      write_csr(pwtc_pkg::CSR_PROP_LIMITS,  {24'(-1000), 24'(1000)});
      write_csr(pwtc_pkg::CSR_INTEG_LIMITS, {24'(50), 24'(-50)});
      write_csr(pwtc_pkg::CSR_DERIV_LIMITS, {24'h7FFFFF, 24'h7FFFFF});
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, '1);
      queue_sample(16'h0000, 16'h0001);
      queue_sample(16'h0001, 16'h0000);
      queue_sample(16'h0000, 16'h00FF);
      queue_sample(16'h0000, 16'h0100);
      queue_sample(16'hFF00, 16'h0000);
      queue_sample(16'h0064, 16'hFF9C);
      queue_sample(16'h0000, 16'h0000);
      wait_drained();

      // Random phases. Each one takes a new setting; phases 1 to 3 add sender gaps,
      // receiver stalls or both, and the last one parks the receiver for a long
      // stretch while the sender keeps pushing.
      track_base = 16'($urandom);
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin gain_flavor = 0; lim_flavor = 0; end
            1: begin gain_flavor = 1; lim_flavor = 0; end
            2: begin gain_flavor = 0; lim_flavor = 1; end
            3: begin gain_flavor = 2; lim_flavor = 2; end
            default: begin
               gain_flavor = $urandom_range(0, 2);
               lim_flavor  = $urandom_range(0, 2);
            end
         endcase
         write_csr(pwtc_pkg::CSR_PROP_GAIN,    {32'($urandom), make_gain(gain_flavor)});
         write_csr(pwtc_pkg::CSR_INTEG_GAIN,   {32'($urandom), make_gain(gain_flavor)});
         write_csr(pwtc_pkg::CSR_DERIV_GAIN,   {32'($urandom), make_gain(gain_flavor)});
         write_csr(pwtc_pkg::CSR_PROP_LIMITS,  make_limits(lim_flavor));
         write_csr(pwtc_pkg::CSR_INTEG_LIMITS, make_limits(lim_flavor));
         write_csr(pwtc_pkg::CSR_DERIV_LIMITS, make_limits(lim_flavor));

         case (ph)
            1:       begin send_idle_pct <= 71; recv_stall_pct <= 0;  end
            2:       begin send_idle_pct <= 0;  recv_stall_pct <= 71; end
            3:       begin send_idle_pct <= 31; recv_stall_pct <= 31; end
            default: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
         endcase

         // Half the samples are arbitrary; the rest track a slowly moving
         // setpoint, which keeps the error small so the integral and
         // derivative terms move without slamming into their clamps.
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if ($urandom_range(0, 31) == 0) track_base = 16'($urandom);
            if ($urandom_range(0, 1)) begin
               queue_sample(16'($urandom), 16'($urandom));
            end else begin
               delta = int'($urandom_range(0, 200)) - 100;
               queue_sample(16'(int'(track_base) + delta), track_base);
            end
         end

         if (ph == RANDOM_PHASES - 1) begin
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         wait_drained();
      end

      $display("Checked %0d drive values from %0d samples across %0d register writes.",
               results_checked, samples_sent, csr_writes);
      $display("Phases: unset registers, extremes, inverted windows, gaps, stalls, hold-off.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/pwtc_pkg.sv
rtl/core/pwtc_csr.sv
rtl/core/pwtc_clamp.sv
rtl/core/pid_with_term_clamps_unit.sv
rtl/core/pwtc_checker.sv
dv/pid_with_term_clamps_unit_tb.sv
